[src/gnss_link_supervisor_macros.svh]
`ifndef GNSS_LINK_SUPERVISOR_MACROS_SVH
`define GNSS_LINK_SUPERVISOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define GLS_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("gls check failed");

// next-cycle implication, checked outside reset
`define GLS_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("gls check failed");

`endif

[src/gls_pkg.sv]
package gls_pkg;

  localparam int BAUD_W = 20;
  localparam int RATE_W = 8;
  localparam int MS_W = 16;
  localparam int TIME_W = 32;
  localparam int PERIOD_W = 10;
  localparam int CNT_W = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int KNOWN_BAUDS = 5;
  localparam int MAX_RATE = 18;
  localparam int RATE_IDX_W = 5;

  localparam logic [BAUD_W-1:0] TARGET_BAUD_RST = 20'd115200;
  localparam logic [RATE_W-1:0] RATE_HZ_RST = 8'd1;
  localparam logic [MS_W-1:0] SWEEP_STEP_RST = 16'd200;
  localparam logic [MS_W-1:0] SILENCE_TIMEOUT_RST = 16'd4000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_BAUD = 2'd0,
    CFG_RATE_HZ = 2'd1,
    CFG_SWEEP_STEP = 2'd2,
    CFG_SILENCE_TIMEOUT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FRAME = 2'd1,
    OP_BEGIN = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_SET_BAUD = 3'd1,
    ACT_PORT_CFG = 3'd2,
    ACT_FULL_CFG = 3'd3,
    ACT_LEGACY_CFG = 3'd4
  } action_t;

  localparam logic [2:0] KIND_PVT = 3'd0;
  localparam logic [2:0] KIND_POSLLH = 3'd1;
  localparam logic [2:0] KIND_DOP = 3'd4;
  localparam logic [2:0] KIND_ACK = 3'd5;
  localparam logic [2:0] KIND_NAK = 3'd6;

  function automatic logic [BAUD_W-1:0] cand_baud(input logic [2:0] i);
    logic [BAUD_W-1:0] b;
    case (i)
      3'd0: b = 20'd115200;
      3'd1: b = 20'd9600;
      3'd2: b = 20'd38400;
      3'd3: b = 20'd57600;
      3'd4: b = 20'd230400;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [PERIOD_W-1:0] period_lut(input logic [RATE_IDX_W-1:0] i);
    logic [PERIOD_W-1:0] p;
    case (i)
      5'd0: p = 10'd1000;
      5'd1: p = 10'd500;
      5'd2: p = 10'd333;
      5'd3: p = 10'd250;
      5'd4: p = 10'd200;
      5'd5: p = 10'd166;
      5'd6: p = 10'd142;
      5'd7: p = 10'd125;
      5'd8: p = 10'd111;
      5'd9: p = 10'd100;
      5'd10: p = 10'd90;
      5'd11: p = 10'd83;
      5'd12: p = 10'd76;
      5'd13: p = 10'd71;
      5'd14: p = 10'd66;
      5'd15: p = 10'd62;
      5'd16: p = 10'd58;
      5'd17: p = 10'd55;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[src/gnss_link_supervisor.sv]
// channel   valid          stall          words
// input     item_valid     item_stall     op, now_ms, frame_kind, payload_ok,
//                                         ack_names_msg_config
// result    result_valid   result_stall   action, baud_rate, request_pvt,
//                                         meas_period_ms, configured, sweep_count,
//                                         pvt_frame_count, legacy_mode
// config    cfg_write      none           cfg_index, cfg_data
//
// one word per cycle sustained while result_stall is low; an accepted word reaches its result
// through the input register, then the state update and result register in one pass
// the registered state update for a word feeds the next word when that word fires
// synchronous active-high reset clears control state and loads config defaults
// result_stall holds the result register and backs up into the input register;
// item_stall rises only when both are full
`include "gnss_link_supervisor_macros.svh"

module gnss_link_supervisor #(
  parameter int NUM_BAUDS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [31:0] now_ms,
  input  logic [2:0]  frame_kind,
  input  logic        payload_ok,
  input  logic        ack_names_msg_config,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  action,
  output logic [19:0] baud_rate,
  output logic        request_pvt,
  output logic [9:0]  meas_period_ms,
  output logic        configured,
  output logic [15:0] sweep_count,
  output logic [15:0] pvt_frame_count,
  output logic        legacy_mode
);
  import gls_pkg::*;

  localparam int SWEEP_W = $clog2(NUM_BAUDS + 1);
  localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(NUM_BAUDS);

  logic [BAUD_W-1:0] target_baud;
  logic [RATE_W-1:0] rate_hz;
  logic [MS_W-1:0] sweep_step_ms;
  logic [MS_W-1:0] silence_timeout_ms;

  logic s1_valid;
  logic [1:0] s1_op;
  logic [TIME_W-1:0] s1_now;
  logic [2:0] s1_kind;
  logic s1_ok;
  logic s1_names_cfg;

  logic started, started_next;
  logic in_parse, in_parse_next;
  logic [SWEEP_W-1:0] sweep_index, sweep_index_next;
  logic [TIME_W-1:0] sweep_stamp, sweep_stamp_next;
  logic [TIME_W-1:0] last_heard, last_heard_next;
  logic awaiting_ack, awaiting_ack_next;
  logic legacy, legacy_next;
  logic [CNT_W-1:0] restarts, restarts_next;
  logic [CNT_W-1:0] pvt_seen, pvt_seen_next;
  logic [PERIOD_W-1:0] period_ms, period_ms_next;

  action_t act;
  logic [BAUD_W-1:0] baud;
  logic req_pvt;

  logic out_free;
  logic fire;
  logic accept;
  logic [RATE_IDX_W-1:0] rate_idx;
  logic [TIME_W-1:0] step_ext;
  logic [TIME_W-1:0] since_step;
  logic [TIME_W-1:0] since_heard;
  logic [BAUD_W-1:0] sweep_baud;

  assign out_free = !result_valid || !result_stall;
  assign fire = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_baud <= TARGET_BAUD_RST;
      rate_hz <= RATE_HZ_RST;
      sweep_step_ms <= SWEEP_STEP_RST;
      silence_timeout_ms <= SILENCE_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_BAUD: target_baud <= cfg_data[BAUD_W-1:0];
        CFG_RATE_HZ: rate_hz <= cfg_data[RATE_W-1:0];
        CFG_SWEEP_STEP: sweep_step_ms <= cfg_data[MS_W-1:0];
        CFG_SILENCE_TIMEOUT: silence_timeout_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || item_stall;
    end
    if (accept) begin
      s1_op <= op;
      s1_now <= now_ms;
      s1_kind <= frame_kind;
      s1_ok <= payload_ok;
      s1_names_cfg <= ack_names_msg_config;
    end
  end

  always_comb begin
    if (rate_hz == '0) begin
      rate_idx = '0;
    end else if (rate_hz > RATE_W'(MAX_RATE)) begin
      rate_idx = RATE_IDX_W'(MAX_RATE - 1);
    end else begin
      rate_idx = RATE_IDX_W'(rate_hz - 1'b1);
    end
  end

  assign step_ext = {{(TIME_W-MS_W){1'b0}}, sweep_step_ms};
  assign since_step = s1_now - sweep_stamp;
  assign since_heard = s1_now - last_heard;
  assign sweep_baud = (32'(sweep_index) < KNOWN_BAUDS) ? cand_baud(3'(sweep_index))
                                                       : target_baud;

  always_comb begin
    started_next = started;
    in_parse_next = in_parse;
    sweep_index_next = sweep_index;
    sweep_stamp_next = sweep_stamp;
    last_heard_next = last_heard;
    awaiting_ack_next = awaiting_ack;
    legacy_next = legacy;
    restarts_next = restarts;
    pvt_seen_next = pvt_seen;
    period_ms_next = period_ms;
    act = ACT_NONE;
    baud = '0;
    req_pvt = 1'b0;
    case (s1_op)
      OP_BEGIN: begin
        period_ms_next = period_lut(rate_idx);
        started_next = 1'b1;
        in_parse_next = 1'b0;
        sweep_index_next = '0;
        sweep_stamp_next = s1_now - step_ext;
        act = ACT_SET_BAUD;
        baud = target_baud;
      end
      OP_TICK: begin
        if (started && !in_parse) begin
          if (since_step >= step_ext) begin
            sweep_stamp_next = s1_now;
            if (sweep_index < SWEEP_LAST) begin
              act = ACT_PORT_CFG;
              baud = sweep_baud;
              sweep_index_next = sweep_index + 1'b1;
            end else begin
              act = ACT_FULL_CFG;
              baud = target_baud;
              req_pvt = !legacy;
              if (!legacy) begin
                awaiting_ack_next = 1'b1;
              end
              last_heard_next = s1_now;
              in_parse_next = 1'b1;
            end
          end
        end else if (started && since_heard > {{(TIME_W-MS_W){1'b0}}, silence_timeout_ms}) begin
          // silence: back to the sweep
          in_parse_next = 1'b0;
          sweep_index_next = '0;
          sweep_stamp_next = s1_now - step_ext;
          restarts_next = sat_inc(restarts);
        end
      end
      OP_FRAME: begin
        if (started) begin
          if (s1_kind == KIND_PVT) begin
            pvt_seen_next = sat_inc(pvt_seen);
            if (s1_ok) begin
              last_heard_next = s1_now;
            end
          end else if (s1_kind inside {[KIND_POSLLH:KIND_DOP]}) begin
            if (s1_ok) begin
              last_heard_next = s1_now;
            end
          end else if (s1_kind inside {KIND_ACK, KIND_NAK}) begin
            if (awaiting_ack && !legacy && s1_ok && s1_names_cfg) begin
              awaiting_ack_next = 1'b0;
              if (s1_kind == KIND_NAK) begin
                legacy_next = 1'b1;
                act = ACT_LEGACY_CFG;
                last_heard_next = s1_now;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      in_parse <= 1'b0;
      sweep_index <= '0;
      sweep_stamp <= '0;
      last_heard <= '0;
      awaiting_ack <= 1'b0;
      legacy <= 1'b0;
      restarts <= '0;
      pvt_seen <= '0;
      period_ms <= PERIOD_RST;
    end else if (fire) begin
      started <= started_next;
      in_parse <= in_parse_next;
      sweep_index <= sweep_index_next;
      sweep_stamp <= sweep_stamp_next;
      last_heard <= last_heard_next;
      awaiting_ack <= awaiting_ack_next;
      legacy <= legacy_next;
      restarts <= restarts_next;
      pvt_seen <= pvt_seen_next;
      period_ms <= period_ms_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= fire || (result_valid && result_stall);
    end
    if (fire) begin
      action <= act;
      baud_rate <= baud;
      request_pvt <= req_pvt;
      meas_period_ms <= period_ms_next;
      configured <= in_parse_next;
      sweep_count <= restarts_next;
      pvt_frame_count <= pvt_seen_next;
      legacy_mode <= legacy_next;
    end
  end

  `GLS_ASSERT_NOW(a_parse_needs_start, in_parse, started)
  `GLS_ASSERT_NOW(a_sweep_index_range, 1'b1, sweep_index <= SWEEP_LAST)
  `GLS_ASSERT_NOW(a_legacy_no_ack_wait, legacy, !awaiting_ack)
  `GLS_ASSERT_NEXT(a_held_word_kept, s1_valid && !out_free, s1_valid && $stable(s1_now))

endmodule
